// ===== hdl/olws_pkg.sv =====
package olws_pkg;

	// Storage geometry of the list.
	localparam int LIST_DEPTH = 64;
	localparam int DATA_WIDTH = 16;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	// Shuffle generator.
	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
	localparam logic [31:0] SEED_RST  = 32'h0000_0001;

	// Action codes on the input beat.
	localparam logic [2:0] ACT_INS_FRONT = 3'd0;
	localparam logic [2:0] ACT_INS_BACK  = 3'd1;
	localparam logic [2:0] ACT_REMOVE    = 3'd2;
	localparam logic [2:0] ACT_READ      = 3'd3;
	localparam logic [2:0] ACT_TAKE      = 3'd4;
	localparam logic [2:0] ACT_SHUFFLE   = 3'd5;

	// Status codes on the result beat.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] value;
		logic [5:0]  position;
	} item_t;

	typedef struct packed {
		logic [15:0] read_value;
		logic [1:0]  status;
		logic [6:0]  entry_count;
	} result_t;

	// Decoded operation handed from the front end to the executor.
	typedef enum logic [2:0] {
		OP_INS_FRONT,
		OP_INS_BACK,
		OP_REMOVE,
		OP_READ,
		OP_TAKE,
		OP_SHUFFLE,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [DATA_WIDTH-1:0] data;
		logic [5:0]            pos;
	} cmd_t;

	// Physical slot of logical position k, counted from the front slot.
	function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] f, logic [CNT_W-1:0] k);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(f) + (CNT_W+1)'(k);
		if (s >= (CNT_W+1)'(LIST_DEPTH)) begin
			s = s - (CNT_W+1)'(LIST_DEPTH);
		end
		return IDX_W'(s);
	endfunction

endpackage

// ===== hdl/olws_front.sv =====
module olws_front import olws_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  item_t item,
	output logic  busy,
	output logic  q_valid,
	output cmd_t  q_cmd,
	input  logic  q_pop
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] q_cnt_q;
	logic       push;
	logic       pop;
	cmd_t       dec;

	// Classify the incoming action and trim the data word.
	always_comb begin
		dec.data = DATA_WIDTH'(item.value);
		dec.pos  = item.position;
		case (item.action)
			ACT_INS_FRONT: dec.op = OP_INS_FRONT;
			ACT_INS_BACK:  dec.op = OP_INS_BACK;
			ACT_REMOVE:    dec.op = OP_REMOVE;
			ACT_READ:      dec.op = OP_READ;
			ACT_TAKE:      dec.op = OP_TAKE;
			ACT_SHUFFLE:   dec.op = OP_SHUFFLE;
			default:       dec.op = OP_NOP;
		endcase
	end

	assign busy    = (q_cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (q_cnt_q != 2'd0);
	assign pop     = q_pop && q_valid;
	assign q_cmd   = fifo_q[rd_ptr_q];

	// Two-entry command queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			q_cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			q_cnt_q <= q_cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q != 2'd3) else $error("queue level out of bounds");
	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> q_cnt_q == $past(q_cnt_q) + 2'd1) else $error("push lost");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> q_cnt_q == $past(q_cnt_q) - 2'd1) else $error("pop lost");

endmodule

// ===== hdl/olws_back.sv =====
module olws_back import olws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	input  logic        cfg_valid,
	input  logic [31:0] cfg_data,
	output logic        done,
	output result_t     result
);

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_RM_RD, S_RM_WR, S_RD_WAIT,
		S_SH_DRAW, S_SH_DIV, S_SH_RDA, S_SH_RDB, S_SH_WRA, S_SH_WRB, S_DONE
	} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [IDX_W-1:0]      front_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      k_q;
	logic [31:0]           lfsr_q;
	logic [31:0]           dvd_q;
	logic [CNT_W-1:0]      rem_q;
	logic [4:0]            bit_q;
	logic [DATA_WIDTH-1:0] ta_q;
	logic [DATA_WIDTH-1:0] rd_val_q;
	logic [1:0]            status_q;

	logic [DATA_WIDTH-1:0] mem [LIST_DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic [IDX_W-1:0]      mem_raddr;

	logic                  is_full;
	logic                  is_empty;
	logic                  pos_bad;
	logic [IDX_W-1:0]      front_dec;
	logic [31:0]           lfsr_nxt;
	logic [CNT_W:0]        div_t;
	logic [CNT_W:0]        div_d;

	assign is_full   = (count_q == CNT_W'(LIST_DEPTH));
	assign is_empty  = (count_q == '0);
	assign pos_bad   = (32'(cmd_q.pos) >= 32'(count_q));
	assign front_dec = (front_q == '0) ? IDX_W'(LIST_DEPTH - 1) : front_q - 1'b1;
	assign lfsr_nxt  = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : 32'h0);
	assign div_t     = {rem_q, dvd_q[31]};
	assign div_d     = (CNT_W+1)'(k_q) + 1'b1;
	assign q_pop     = (state_q == S_IDLE);

	// Memory port addresses for the current step.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_of(front_q, k_q);
		mem_wdata = rdata_q;
		mem_raddr = front_q;
		case (state_q)
			S_EXEC: begin
				if (cmd_q.op == OP_INS_FRONT) begin
					mem_we    = !is_full;
					mem_waddr = front_dec;
					mem_wdata = cmd_q.data;
				end else if (cmd_q.op == OP_INS_BACK) begin
					mem_we    = !is_full;
					mem_waddr = slot_of(front_q, count_q);
					mem_wdata = cmd_q.data;
				end else if (cmd_q.op == OP_READ) begin
					mem_raddr = slot_of(front_q, CNT_W'(cmd_q.pos));
				end
			end
			S_RM_RD:  mem_raddr = slot_of(front_q, k_q + 1'b1);
			S_RM_WR:  mem_we = 1'b1;
			S_SH_RDA: mem_raddr = slot_of(front_q, k_q);
			S_SH_RDB: mem_raddr = slot_of(front_q, rem_q);
			S_SH_WRA: mem_we = 1'b1;
			S_SH_WRB: begin
				mem_we    = 1'b1;
				mem_waddr = slot_of(front_q, rem_q);
				mem_wdata = ta_q;
			end
			default: ;
		endcase
	end

	// Entry store with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Executor sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			front_q  <= '0;
			count_q  <= '0;
			lfsr_q   <= SEED_RST;
			k_q      <= '0;
			rem_q    <= '0;
			bit_q    <= '0;
			status_q <= ST_OK;
			rd_val_q <= '0;
		end else begin
			if (cfg_valid) begin
				lfsr_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q   <= q_cmd;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= ST_OK;
					rd_val_q <= '0;
					state_q  <= S_DONE;
					case (cmd_q.op)
						OP_INS_FRONT: begin
							if (is_full) begin
								status_q <= ST_FULL;
							end else begin
								front_q <= front_dec;
								count_q <= count_q + 1'b1;
							end
						end
						OP_INS_BACK: begin
							if (is_full) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
						OP_REMOVE, OP_READ: begin
							if (is_empty) begin
								status_q <= ST_EMPTY;
							end else if (pos_bad) begin
								status_q <= ST_RANGE;
							end else if (cmd_q.op == OP_REMOVE) begin
								k_q     <= CNT_W'(cmd_q.pos);
								state_q <= S_RM_RD;
							end else begin
								state_q <= S_RD_WAIT;
							end
						end
						OP_TAKE: begin
							if (is_empty) begin
								status_q <= ST_EMPTY;
							end else begin
								state_q <= S_RD_WAIT;
							end
						end
						OP_SHUFFLE: begin
							if (count_q > CNT_W'(1)) begin
								k_q     <= count_q - 1'b1;
								state_q <= S_SH_DRAW;
							end
						end
						default: ;
					endcase
				end
				S_RM_RD: begin
					if (k_q + 1'b1 < count_q) begin
						state_q <= S_RM_WR;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_RM_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= S_RM_RD;
				end
				S_RD_WAIT: begin
					rd_val_q <= rdata_q;
					if (cmd_q.op == OP_TAKE) begin
						front_q <= slot_of(front_q, CNT_W'(1));
						count_q <= count_q - 1'b1;
					end
					state_q <= S_DONE;
				end
				S_SH_DRAW: begin
					lfsr_q  <= lfsr_nxt;
					dvd_q   <= lfsr_nxt;
					rem_q   <= '0;
					bit_q   <= '0;
					state_q <= S_SH_DIV;
				end
				S_SH_DIV: begin
					// One remainder bit per cycle against divisor k+1.
					if (div_t >= div_d) begin
						rem_q <= CNT_W'(div_t - div_d);
					end else begin
						rem_q <= CNT_W'(div_t);
					end
					dvd_q <= dvd_q << 1;
					bit_q <= bit_q + 1'b1;
					if (bit_q == 5'd31) begin
						state_q <= S_SH_RDA;
					end
				end
				S_SH_RDA: state_q <= S_SH_RDB;
				S_SH_RDB: begin
					ta_q    <= rdata_q;
					state_q <= S_SH_WRA;
				end
				S_SH_WRA: state_q <= S_SH_WRB;
				S_SH_WRB: begin
					k_q     <= k_q - 1'b1;
					state_q <= (k_q == CNT_W'(1)) ? S_DONE : S_SH_DRAW;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done               = (state_q == S_DONE);
	assign result.read_value  = 16'(rd_val_q);
	assign result.status      = status_q;
	assign result.entry_count = 7'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= LIST_DEPTH) else $error("count above depth");
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_FULL) |-> is_full) else $error("full status with room left");
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_EMPTY) |-> is_empty) else $error("empty status on filled list");
	a_swap_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SH_DRAW) |-> (k_q != '0 && k_q < count_q)) else $error("bad swap index");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SH_RDA) |-> rem_q <= k_q) else $error("draw remainder out of range");

endmodule

// ===== hdl/ordered_list_with_shuffle.sv =====
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+-------------------------------------
// item in  | start, busy, item              | beat taken when start and not busy
// result   | done, result                   | one-cycle strobe, no back-pressure
// seed cfg | cfg_valid, cfg_ready, cfg_data | beat taken when valid and ready
//
// Items pass through a two-entry command queue; busy is high only when it is full.
// Insert goes straight to done; read at and take first add a wait; remove shifts in a loop.
// Shuffle draws and reduces with the one-bit-per-cycle remainder unit, then swaps, per entry.
// Reset clears the list, the queue and the executor; the generator reloads seed 1.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ordered_list_with_shuffle import olws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  item_t       item,
	output logic        busy,
	output logic        done,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	assign cfg_ready = 1'b1;

	// Front end: decode and queue commands.
	olws_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item    (item),
		.busy    (busy),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	// Back end: list store and sequencer.
	olws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import olws_pkg::*;

	// Action codes the block ignores.
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 3000;

	// Keeps a private copy of the list and generator and checks every result beat.
	class list_scoreboard;
		logic [15:0] slots [LIST_DEPTH];
		logic [5:0]  front;
		int          held;
		logic [31:0] seed;
		logic [31:0] lfsr;
		result_t     pending [$];
		int          errors;

		function new();
			front = '0;
			held = 0;
			seed = SEED_RST;
			lfsr = SEED_RST;
			errors = 0;
			foreach (slots[i]) slots[i] = '0;
		endfunction

		function void load_seed(logic [31:0] s);
			seed = s;
			lfsr = s;
		endfunction

		function logic [5:0] slot(int k);
			return 6'((int'(front) + k) % LIST_DEPTH);
		endfunction

		function logic [31:0] next_draw();
			logic out_bit;
			out_bit = lfsr[0];
			lfsr = lfsr >> 1;
			if (out_bit) lfsr = lfsr ^ LFSR_MASK;
			return lfsr;
		endfunction

		// Apply one accepted input beat and queue the result it must produce.
		function void note_item(item_t it);
			result_t r;
			int pos;
			int j;
			logic [15:0] t;
			r = '0;
			r.status = ST_OK;
			pos = int'(it.position);
			case (it.action)
				ACT_INS_FRONT: begin
					if (held >= LIST_DEPTH) r.status = ST_FULL;
					else begin
						front = front - 6'd1;
						slots[front] = it.value;
						held++;
					end
				end
				ACT_INS_BACK: begin
					if (held >= LIST_DEPTH) r.status = ST_FULL;
					else begin
						slots[slot(held)] = it.value;
						held++;
					end
				end
				ACT_REMOVE: begin
					if (held == 0) r.status = ST_EMPTY;
					else if (pos >= held) r.status = ST_RANGE;
					else begin
						for (int k = pos; k + 1 < held; k++) slots[slot(k)] = slots[slot(k + 1)];
						held--;
					end
				end
				ACT_READ: begin
					if (held == 0) r.status = ST_EMPTY;
					else if (pos >= held) r.status = ST_RANGE;
					else r.read_value = slots[slot(pos)];
				end
				ACT_TAKE: begin
					if (held == 0) r.status = ST_EMPTY;
					else begin
						r.read_value = slots[front];
						front = front + 6'd1;
						held--;
					end
				end
				ACT_SHUFFLE: begin
					// Fisher-Yates from the last entry down to entry 1.
					for (int k = held - 1; k > 0; k--) begin
						j = int'(next_draw() % (k + 1));
						t = slots[slot(k)];
						slots[slot(k)] = slots[slot(j)];
						slots[slot(j)] = t;
					end
				end
				default: begin
				end
			endcase
			r.entry_count = 7'(held);
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$display("%0t: result with nothing expected: got %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.read_value !== want.read_value) begin
				$display("%0t: read_value expected %h actual %h", $time,
					want.read_value, got.read_value);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$display("%0t: entry_count expected %0d actual %0d", $time,
					want.entry_count, got.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	item_t       item = '0;
	logic        busy;
	logic        done;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	list_scoreboard board = new();
	int idle_cycles = 0;

	ordered_list_with_shuffle dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Check each result beat at the edge that ends its cycle.
	always @(posedge clk) begin
		if (done) board.check_result(result);
	end

	// Watchdog on cycles with no beat moving anywhere.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Send one input beat after a random gap; start stays high if there is no gap.
	task automatic send_item(logic [2:0] act, logic [15:0] val, logic [5:0] pos);
		int gap;
		item_t it;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.action = act;
		it.value = val;
		it.position = pos;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		board.note_item(it);
	endtask

	// Wait until every result is in, then write the seed register.
	task automatic write_seed(logic [31:0] s);
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= s;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.load_seed(s);
	endtask

	// Random beat: insert share in percent, positions mostly inside the list.
	task automatic random_item(int ins_pct);
		logic [2:0] act;
		logic [5:0] pos;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct) act = ($urandom_range(0, 1) == 0) ? ACT_INS_FRONT : ACT_INS_BACK;
		else if (roll >= 97) act = ($urandom_range(0, 1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7;
		else begin
			case ($urandom_range(0, 9))
				0, 1, 2: act = ACT_READ;
				3, 4:    act = ACT_REMOVE;
				5, 6, 7: act = ACT_TAKE;
				default: act = ACT_SHUFFLE;
			endcase
		end
		if (board.held > 0 && $urandom_range(0, 4) != 0)
			pos = 6'($urandom_range(0, board.held - 1));
		else pos = 6'($urandom);
		send_item(act, 16'($urandom), pos);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty list, extremes of fields, every action.
		send_item(ACT_READ, 16'h0000, 6'd0);
		send_item(ACT_REMOVE, 16'hffff, 6'd0);
		send_item(ACT_TAKE, 16'h0000, 6'd63);
		send_item(ACT_SHUFFLE, 16'h0000, 6'd0);
		send_item(ACT_INS_FRONT, 16'hffff, 6'd63);
		send_item(ACT_SHUFFLE, 16'h0000, 6'd0);
		send_item(ACT_INS_BACK, 16'h0000, 6'd0);
		send_item(ACT_INS_FRONT, 16'h8001, 6'd0);
		send_item(ACT_INS_BACK, 16'h7ffe, 6'd0);
		send_item(ACT_READ, 16'h0000, 6'd3);
		send_item(ACT_READ, 16'h0000, 6'd4);
		send_item(ACT_READ, 16'h0000, 6'd63);
		send_item(ACT_SHUFFLE, 16'h0000, 6'd0);
		send_item(ACT_READ, 16'h0000, 6'd0);
		send_item(ACT_REMOVE, 16'h0000, 6'd1);
		send_item(ACT_REMOVE, 16'h0000, 6'd63);
		send_item(ACT_SPARE_6, 16'hffff, 6'd63);
		send_item(ACT_SPARE_7, 16'h1234, 6'd0);
		send_item(ACT_TAKE, 16'h0000, 6'd0);
		send_item(ACT_REMOVE, 16'h0000, 6'd0);
		send_item(ACT_TAKE, 16'h0000, 6'd0);

		// Random phases over several seeds, including the zero and all-ones extremes.
		write_seed(32'hffff_ffff);
		repeat (90) random_item(85);
		repeat (20) random_item(30);
		write_seed(32'h0000_0000);
		repeat (100) random_item(50);
		write_seed(32'h0000_0001);
		repeat (100) random_item(40);
		write_seed($urandom | 32'h1);
		repeat (70) random_item(90);
		repeat (40) random_item(10);
		write_seed($urandom);
		repeat (110) random_item(45);

		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

endmodule
